// ----- design/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_LEAD,
    PH_META_TYPE,
    PH_META_LEN,
    PH_SYSEX_LEN,
    PH_PAYLOAD,
    PH_DATA1,
    PH_DATA2
  } phase_t;

  localparam logic [7:0] META_LEAD   = 8'hFF;
  localparam logic [7:0] SYSEX_LEAD  = 8'hF0;
  localparam logic [7:0] ESCAPE_LEAD = 8'hF7;
  localparam logic [3:0] NIB_PROG    = 4'hC;
  localparam logic [3:0] NIB_PRESS   = 4'hD;
  localparam int unsigned LEN_W      = 28;
  localparam int unsigned RES_DEPTH  = 4;
  localparam int unsigned RES_PTR_W  = 2;
  localparam int unsigned RES_CNT_W  = 3;

  typedef struct packed {
    logic [31:0] event_time;
    logic [3:0]  byte_index;
    logic [7:0]  event_byte;
    logic        last_of_event;
    logic        truncated;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ----- design/mtep_core.sv -----
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and per-byte decode; yields up to two results per request.
// ----------------------------------------------------------------------------
module mtep_core #(
  parameter int unsigned EVENT_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      byte_in,
  input  logic            chunk_last,
  input  logic            track_start,
  output mtep_pkg::push_t push
);

  localparam int unsigned KW = $clog2(EVENT_BYTES + 1);

  mtep_pkg::phase_t             phase_r, phase_nxt;
  logic [31:0]                  time_r, time_nxt;
  logic [31:0]                  acc_r, acc_nxt;
  logic [7:0]                   rs_r, rs_nxt;
  logic [7:0]                   lead_r, lead_nxt;
  logic [mtep_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [KW-1:0]                kept_r, kept_nxt;
  logic [KW+3:0]                kept_ext;
  logic [31:0]                  acc_shift;
  logic [mtep_pkg::LEN_W-1:0]   len;
  logic [mtep_pkg::LEN_W-1:0]   rem_dec;
  logic                         done;
  logic                         fin;
  mtep_pkg::push_t              p;

  function automatic mtep_pkg::res_t mk(input logic [31:0] t, input logic [3:0] idx,
                                        input logic [7:0] b, input logic last,
                                        input logic err);
    mtep_pkg::res_t r;
    r.event_time    = t;
    r.byte_index    = idx;
    r.event_byte    = b;
    r.last_of_event = last;
    r.truncated     = err;
    return r;
  endfunction

  function automatic logic two_byte(input logic [7:0] st);
    return (st[7:4] == mtep_pkg::NIB_PROG) || (st[7:4] == mtep_pkg::NIB_PRESS);
  endfunction

  always_comb begin
    phase_nxt = track_start ? mtep_pkg::PH_DELTA : phase_r;
    time_nxt  = track_start ? 32'd0 : time_r;
    acc_nxt   = track_start ? 32'd0 : acc_r;
    rs_nxt    = track_start ? 8'd0 : rs_r;
    rem_nxt   = track_start ? '0 : rem_r;
    kept_nxt  = track_start ? '0 : kept_r;
    lead_nxt  = lead_r;
    kept_ext  = {4'b0000, kept_nxt};
    acc_shift = {acc_nxt[24:0], byte_in[6:0]};
    len       = acc_shift[mtep_pkg::LEN_W-1:0];
    rem_dec   = rem_nxt - 1'b1;
    fin       = 1'b0;
    done      = 1'b0;
    p.v0      = 1'b0;
    p.v1      = 1'b0;
    p.r0      = mk(time_nxt, 4'd0, byte_in, 1'b0, 1'b0);
    p.r1      = mk(time_nxt, 4'd1, byte_in, 1'b0, 1'b0);

    unique case (phase_nxt)
      mtep_pkg::PH_DELTA: begin
        acc_nxt = acc_shift;
        if (!byte_in[7]) begin
          time_nxt  = time_nxt + acc_shift;
          acc_nxt   = 32'd0;
          phase_nxt = mtep_pkg::PH_LEAD;
        end
      end
      mtep_pkg::PH_LEAD: begin
        if (byte_in == mtep_pkg::META_LEAD) begin
          p.v0      = 1'b1;
          phase_nxt = mtep_pkg::PH_META_TYPE;
        end else if (byte_in == mtep_pkg::SYSEX_LEAD || byte_in == mtep_pkg::ESCAPE_LEAD) begin
          lead_nxt  = byte_in;
          acc_nxt   = 32'd0;
          phase_nxt = mtep_pkg::PH_SYSEX_LEN;
        end else if (byte_in[7]) begin
          lead_nxt  = byte_in;
          p.v0      = 1'b1;
          phase_nxt = mtep_pkg::PH_DATA1;
        end else begin
          lead_nxt = rs_nxt;
          p.v0     = 1'b1;
          p.r0     = mk(time_nxt, 4'd0, rs_nxt, 1'b0, 1'b0);
          p.v1     = 1'b1;
          if (two_byte(rs_nxt)) begin
            p.r1 = mk(time_nxt, 4'd1, byte_in, 1'b1, 1'b0);
            done = 1'b1;
          end else begin
            phase_nxt = mtep_pkg::PH_DATA2;
          end
        end
      end
      mtep_pkg::PH_META_TYPE: begin
        lead_nxt  = byte_in;
        acc_nxt   = 32'd0;
        phase_nxt = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
        acc_nxt = acc_shift;
        if (!byte_in[7]) begin
          acc_nxt = 32'd0;
          p.v0    = 1'b1;
          p.r0    = mk(time_nxt, (phase_nxt == mtep_pkg::PH_META_LEN) ? 4'd1 : 4'd0,
                       lead_nxt, (len == '0), 1'b0);
          if (len == '0) begin
            done = 1'b1;
          end else begin
            rem_nxt   = len;
            kept_nxt  = (phase_nxt == mtep_pkg::PH_META_LEN) ? KW'(2) : KW'(1);
            phase_nxt = mtep_pkg::PH_PAYLOAD;
          end
        end
      end
      mtep_pkg::PH_PAYLOAD: begin
        rem_nxt = rem_dec;
        if (kept_nxt < KW'(EVENT_BYTES)) begin
          fin      = (rem_dec == '0) || (kept_nxt == KW'(EVENT_BYTES - 1));
          p.v0     = 1'b1;
          p.r0     = mk(time_nxt, kept_ext[3:0], byte_in, fin, 1'b0);
          kept_nxt = kept_nxt + 1'b1;
        end
        if (rem_dec == '0) begin
          done = 1'b1;
        end
      end
      mtep_pkg::PH_DATA1: begin
        p.v0 = 1'b1;
        if (two_byte(lead_nxt)) begin
          p.r0 = mk(time_nxt, 4'd1, byte_in, 1'b1, 1'b0);
          done = 1'b1;
        end else begin
          p.r0      = mk(time_nxt, 4'd1, byte_in, 1'b0, 1'b0);
          phase_nxt = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        p.v0 = 1'b1;
        p.r0 = mk(time_nxt, 4'd2, byte_in, 1'b1, 1'b0);
        done = 1'b1;
      end
      default: begin
        phase_nxt = mtep_pkg::PH_DELTA;
        acc_nxt   = 32'd0;
      end
    endcase

    if (done) begin
      if (phase_nxt == mtep_pkg::PH_LEAD || phase_nxt == mtep_pkg::PH_DATA1 ||
          phase_nxt == mtep_pkg::PH_DATA2) begin
        rs_nxt = lead_nxt;
      end
      phase_nxt = mtep_pkg::PH_DELTA;
      acc_nxt   = 32'd0;
      rem_nxt   = '0;
      kept_nxt  = '0;
    end else if (chunk_last) begin
      p.v0      = 1'b1;
      p.v1      = 1'b0;
      p.r0      = mk(time_nxt, 4'd0, 8'd0, 1'b1, 1'b1);
      phase_nxt = mtep_pkg::PH_DELTA;
      acc_nxt   = 32'd0;
      rem_nxt   = '0;
      kept_nxt  = '0;
    end

    push    = p;
    push.v0 = p.v0 & fire;
    push.v1 = p.v1 & fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mtep_pkg::PH_DELTA;
      time_r  <= 32'd0;
      acc_r   <= 32'd0;
      rs_r    <= 8'd0;
      lead_r  <= 8'd0;
      rem_r   <= '0;
      kept_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      time_r  <= time_nxt;
      acc_r   <= acc_nxt;
      rs_r    <= rs_nxt;
      lead_r  <= lead_nxt;
      rem_r   <= rem_nxt;
      kept_r  <= kept_nxt;
    end
  end

endmodule

// ----- design/mtep_resq.sv -----
// ----------------------------------------------------------------------------
// mtep_resq
// Result queue: takes up to two results a cycle, delivers one when out_stall is low.
// ----------------------------------------------------------------------------
module mtep_resq (
  input  logic            clk,
  input  logic            rst_n,
  input  mtep_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output mtep_pkg::res_t  out_res
);

  mtep_pkg::res_t                   mem_r [mtep_pkg::RES_DEPTH];
  logic [mtep_pkg::RES_PTR_W-1:0]   head_r, head_nxt;
  logic [mtep_pkg::RES_PTR_W-1:0]   tail_r, tail_nxt;
  logic [mtep_pkg::RES_PTR_W-1:0]   tail_p1;
  logic [mtep_pkg::RES_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[head_r];
  assign room      = (cnt_r <= mtep_pkg::RES_CNT_W'(mtep_pkg::RES_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign tail_p1   = tail_r + 1'b1;

  always_comb begin
    head_nxt = head_r + mtep_pkg::RES_PTR_W'(pop);
    tail_nxt = tail_r + mtep_pkg::RES_PTR_W'(push.v0) + mtep_pkg::RES_PTR_W'(push.v1);
    cnt_nxt  = cnt_r + mtep_pkg::RES_CNT_W'(push.v0) + mtep_pkg::RES_CNT_W'(push.v1)
               - mtep_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[tail_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[tail_p1] <= push.r1;
    end
  end

endmodule

// ----- design/midi_track_event_parser_unit.sv -----
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// Track chunk event parser: one chunk byte per request in, event bytes out.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | in        | in_byte, in_chunk_last, in_track_start
//  out_    | out       | out_event_time, out_byte_index, out_event_byte,
//          |           | out_last_of_event, out_truncated
//
// One byte per cycle is taken while in_stall is low. Each byte is registered
// in the input register, then its results are written into the result queue.
// A status byte reused under running status gives two results from one byte;
// these drain one per cycle, while out_stall is low, via a four-entry queue.
// Synchronous active-low reset clears parser state and queue.
// in_stall rises when the input register holds a byte and the queue lacks
// room for two results.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit #(
  parameter int unsigned EVENT_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_chunk_last,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_event_time,
  output logic [3:0]  out_byte_index,
  output logic [7:0]  out_event_byte,
  output logic        out_last_of_event,
  output logic        out_truncated
);

  logic            stage_v_r;
  logic [7:0]      stage_byte_r;
  logic            stage_last_r;
  logic            stage_ts_r;
  logic            room;
  logic            fire;
  mtep_pkg::push_t push;
  mtep_pkg::res_t  res;

  assign fire     = stage_v_r && room;
  assign in_stall = stage_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_v_r <= 1'b1;
    end else if (fire) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_byte_r <= in_byte;
      stage_last_r <= in_chunk_last;
      stage_ts_r   <= in_track_start;
    end
  end

  mtep_core #(
    .EVENT_BYTES(EVENT_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .byte_in     (stage_byte_r),
    .chunk_last  (stage_last_r),
    .track_start (stage_ts_r),
    .push        (push)
  );

  mtep_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_event_time    = res.event_time;
  assign out_byte_index    = res.byte_index;
  assign out_event_byte    = res.event_byte;
  assign out_last_of_event = res.last_of_event;
  assign out_truncated     = res.truncated;

endmodule
